// ===== rtl/http_date_parser_core_assert.svh =====
// Assertion macros for the HTTP date parser core.
// Included by the top level; depends on nothing else.
`ifndef HTTP_DATE_PARSER_CORE_ASSERT_SVH
`define HTTP_DATE_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("http date parser: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("http date parser: assertion failed");

`endif

// ===== rtl/hdp_pkg.sv =====
// Package of the HTTP date parser: widths, character and position constants,
// month decoding and the controller/datapath command and status types. No dependencies.
package hdp_pkg;

    // Field and intermediate widths.
    localparam int POS_W    = 5;
    localparam int FIELD_W  = 7;
    localparam int YEAR_W   = 14;
    localparam int MON_W    = 4;
    localparam int DOY_W    = 9;
    localparam int Y365_W   = 22;
    localparam int PROD_W   = 27;
    localparam int DAYS_W   = 23;
    localparam int TOD_W    = 19;
    localparam int EPOCH_W  = 39;
    localparam int SECS_W   = 40;

    // Character positions within the date string.
    localparam logic [POS_W-1:0] DATE_LEN     = 5'd29;
    localparam logic [POS_W-1:0] POS_COMMA    = 5'd3;
    localparam logic [POS_W-1:0] POS_DAY_LO   = 5'd5;
    localparam logic [POS_W-1:0] POS_DAY_HI   = 5'd6;
    localparam logic [POS_W-1:0] POS_MON_LO   = 5'd8;
    localparam logic [POS_W-1:0] POS_MON_HI   = 5'd10;
    localparam logic [POS_W-1:0] POS_YEAR_LO  = 5'd12;
    localparam logic [POS_W-1:0] POS_YEAR_HI  = 5'd15;
    localparam logic [POS_W-1:0] POS_HOUR_LO  = 5'd17;
    localparam logic [POS_W-1:0] POS_HOUR_HI  = 5'd18;
    localparam logic [POS_W-1:0] POS_MIN_LO   = 5'd20;
    localparam logic [POS_W-1:0] POS_MIN_HI   = 5'd21;
    localparam logic [POS_W-1:0] POS_SEC_LO   = 5'd23;
    localparam logic [POS_W-1:0] POS_SEC_HI   = 5'd24;

    // Character codes.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_D  = 8'h44;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_UC_J  = 8'h4A;
    localparam logic [7:0] CHAR_UC_M  = 8'h4D;
    localparam logic [7:0] CHAR_UC_N  = 8'h4E;
    localparam logic [7:0] CHAR_UC_O  = 8'h4F;
    localparam logic [7:0] CHAR_UC_S  = 8'h53;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_G  = 8'h67;
    localparam logic [7:0] CHAR_LC_L  = 8'h6C;
    localparam logic [7:0] CHAR_LC_N  = 8'h6E;
    localparam logic [7:0] CHAR_LC_R  = 8'h72;
    localparam logic [7:0] CHAR_LC_U  = 8'h75;
    localparam logic [7:0] CHAR_LC_Y  = 8'h79;

    // Month codes, January first.
    localparam logic [MON_W-1:0] MON_JAN = 4'd0;
    localparam logic [MON_W-1:0] MON_FEB = 4'd1;
    localparam logic [MON_W-1:0] MON_MAR = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd3;
    localparam logic [MON_W-1:0] MON_MAY = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd5;
    localparam logic [MON_W-1:0] MON_JUL = 4'd6;
    localparam logic [MON_W-1:0] MON_AUG = 4'd7;
    localparam logic [MON_W-1:0] MON_SEP = 4'd8;
    localparam logic [MON_W-1:0] MON_OCT = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd10;
    localparam logic [MON_W-1:0] MON_DEC = 4'd11;

    // Date arithmetic. The year is shifted up by one 400-year cycle so that
    // every floor division works on a non-negative value.
    localparam logic [YEAR_W-1:0] YEAR_BIAS     = 14'd400;
    localparam logic [Y365_W-1:0] DAYS_PER_YEAR = 22'd365;
    // Division by 100 as a multiply by 5243 and a shift by 19; exact below 43690.
    localparam logic [PROD_W-1:0] DIV100_MUL    = 27'd5243;
    localparam int                DIV100_SHIFT  = 19;
    // Days from the shifted March-based calendar origin to 1970-01-01, plus one
    // for the first day of the month.
    localparam logic [DAYS_W-1:0] DAYS_BIAS     = 23'd865566;
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 19'd3600;
    localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 19'd60;
    localparam logic signed [SECS_W-1:0] SECS_PER_DAY = 40'sd86400;

    // Decoded month.
    typedef struct packed {
        logic             ok;
        logic [MON_W-1:0] idx;
    } t_month;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_char;
        logic calc_a;
        logic calc_b;
        logic load_out;
    } t_hdp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } t_hdp_status;

    // Lenient month decoding of the three month characters.
    function automatic t_month month_decode(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        t_month m;
        m.ok  = 1'b1;
        m.idx = MON_JAN;
        unique case (a)
            CHAR_UC_J: begin
                if (b == CHAR_LC_A) begin
                    m.idx = MON_JAN;
                end else if (b == CHAR_LC_U && c == CHAR_LC_N) begin
                    m.idx = MON_JUN;
                end else if (b == CHAR_LC_U && c == CHAR_LC_L) begin
                    m.idx = MON_JUL;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CHAR_UC_F: m.idx = MON_FEB;
            CHAR_UC_M: begin
                if (b == CHAR_LC_A && c == CHAR_LC_R) begin
                    m.idx = MON_MAR;
                end else if (b == CHAR_LC_A && c == CHAR_LC_Y) begin
                    m.idx = MON_MAY;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CHAR_UC_A: begin
                if (c == CHAR_LC_R) begin
                    m.idx = MON_APR;
                end else if (c == CHAR_LC_G) begin
                    m.idx = MON_AUG;
                end else begin
                    m.ok = 1'b0;
                end
            end
            CHAR_UC_S: m.idx = MON_SEP;
            CHAR_UC_O: m.idx = MON_OCT;
            CHAR_UC_N: m.idx = MON_NOV;
            CHAR_UC_D: m.idx = MON_DEC;
            default:   m.ok  = 1'b0;
        endcase
        return m;
    endfunction

    // Day of a year that starts on 1 March, for the first of each month.
    function automatic logic [DOY_W-1:0] month_doy(input logic [MON_W-1:0] idx);
        logic [DOY_W-1:0] d;
        unique case (idx)
            MON_JAN: d = 9'd306;
            MON_FEB: d = 9'd337;
            MON_MAR: d = 9'd0;
            MON_APR: d = 9'd31;
            MON_MAY: d = 9'd61;
            MON_JUN: d = 9'd92;
            MON_JUL: d = 9'd122;
            MON_AUG: d = 9'd153;
            MON_SEP: d = 9'd184;
            MON_OCT: d = 9'd214;
            MON_NOV: d = 9'd245;
            MON_DEC: d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/hdp_char_if.sv =====
// Character channel of the HTTP date parser: valid, ready and one character a beat.
// Depends on nothing else.
interface hdp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== rtl/hdp_date_if.sv =====
// Result channel of the HTTP date parser: valid, ready and one parsed date a beat.
// Depends on hdp_pkg.
interface hdp_date_if import hdp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic                      date_valid;

    modport source (output valid, output epoch_seconds, output date_valid, input ready);
    modport sink   (input valid, input epoch_seconds, input date_valid, output ready);
endinterface

// ===== rtl/hdp_ctrl.sv =====
// Controller of the HTTP date parser: sequences character collection and the
// three arithmetic steps. Depends on hdp_pkg.
module hdp_ctrl import hdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_last,
    input  logic        i_out_ready,
    input  t_hdp_status i_status,
    output logic        o_in_ready,
    output t_hdp_cmd    o_cmd
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_CALC_A  = 2'd1;
    localparam logic [1:0] ST_CALC_B  = 2'd2;
    localparam logic [1:0] ST_CALC_C  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_COLLECT: begin
                o_in_ready      = 1'b1;
                o_cmd.take_char = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_CALC_A;
                end
            end
            ST_CALC_A: begin
                o_cmd.calc_a = 1'b1;
                n_state      = ST_CALC_B;
            end
            ST_CALC_B: begin
                o_cmd.calc_b = 1'b1;
                n_state      = ST_CALC_C;
            end
            ST_CALC_C: begin
                // Wait here only while the previous result is still held.
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_COLLECT;
                end
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/hdp_datapath.sv =====
// Datapath of the HTTP date parser: field accumulators, month decoding, the
// three-step date arithmetic and the result register. Depends on hdp_pkg.
module hdp_datapath import hdp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_char_code,
    input  t_hdp_cmd                  i_cmd,
    input  logic                      i_out_ready,
    output t_hdp_status               o_status,
    output logic                      o_out_valid,
    output logic signed [EPOCH_W-1:0] o_epoch_seconds,
    output logic                      o_date_valid
);

    // Collection state.
    logic [POS_W-1:0]   r_pos,  n_pos;
    logic               r_ovf,  n_ovf;
    logic               r_fbad, n_fbad;
    logic [FIELD_W-1:0] r_day,  n_day;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [FIELD_W-1:0] r_hour, n_hour;
    logic [FIELD_W-1:0] r_min,  n_min;
    logic [FIELD_W-1:0] r_sec,  n_sec;
    logic [7:0]         r_mon [3];
    logic [7:0]         n_mon [3];

    // Arithmetic stages.
    logic [Y365_W-1:0]        r_y365;
    logic [YEAR_W-3:0]        r_q4;
    logic [6:0]               r_c100;
    logic [4:0]               r_c400;
    logic [DOY_W-1:0]         r_doy;
    logic [FIELD_W-1:0]       r_dom;
    logic [TOD_W-1:0]         r_tod;
    logic                     r_ok;
    logic signed [DAYS_W-1:0] r_days;

    // Result register.
    logic                      r_out_valid;
    logic signed [EPOCH_W-1:0] r_epoch;
    logic                      r_date_valid;

    logic               w_digit;
    logic [3:0]         w_dval;
    logic [1:0]         w_mon_sel;
    t_month             w_month;
    logic               w_adj;
    logic [YEAR_W-1:0]  w_year_sh;
    logic [YEAR_W-3:0]  w_q4;
    logic [PROD_W-1:0]  w_div100_prod;
    logic [PROD_W-1:0]  w_div400_prod;
    logic [Y365_W-1:0]  w_y365;
    logic [TOD_W-1:0]   w_tod;
    logic [DAYS_W-1:0]  w_days;
    logic signed [SECS_W-1:0] w_prod;
    logic [SECS_W-1:0]  w_secs;

    // Character classification.
    assign w_digit   = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign w_dval    = w_digit ? 4'(i_char_code - CHAR_ZERO) : 4'd0;
    assign w_mon_sel = 2'(r_pos - POS_MON_LO);

    // Character collection: one character a beat into the field it belongs to.
    always_comb begin
        n_pos  = r_pos;
        n_ovf  = r_ovf;
        n_fbad = r_fbad;
        n_day  = r_day;
        n_year = r_year;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_mon  = r_mon;
        if (i_cmd.load_out) begin
            n_pos  = '0;
            n_ovf  = 1'b0;
            n_fbad = 1'b0;
            n_day  = '0;
            n_year = '0;
            n_hour = '0;
            n_min  = '0;
            n_sec  = '0;
            n_mon  = '{default: '0};
        end else if (i_cmd.take_char) begin
            if (r_pos < DATE_LEN) begin
                n_pos = r_pos + 5'd1;
                case (r_pos) inside
                    [POS_DAY_LO:POS_DAY_HI]: begin
                        n_day = 7'(8'(r_day) * 8'd10 + 8'(w_dval));
                        if (!w_digit) n_fbad = 1'b1;
                    end
                    [POS_YEAR_LO:POS_YEAR_HI]: begin
                        n_year = 14'(r_year * 14'd10 + 14'(w_dval));
                        if (!w_digit) n_fbad = 1'b1;
                    end
                    [POS_HOUR_LO:POS_HOUR_HI]: begin
                        n_hour = 7'(8'(r_hour) * 8'd10 + 8'(w_dval));
                        if (!w_digit) n_fbad = 1'b1;
                    end
                    [POS_MIN_LO:POS_MIN_HI]: begin
                        n_min = 7'(8'(r_min) * 8'd10 + 8'(w_dval));
                        if (!w_digit) n_fbad = 1'b1;
                    end
                    [POS_SEC_LO:POS_SEC_HI]: begin
                        n_sec = 7'(8'(r_sec) * 8'd10 + 8'(w_dval));
                        if (!w_digit) n_fbad = 1'b1;
                    end
                    [POS_MON_LO:POS_MON_HI]: begin
                        n_mon[w_mon_sel] = i_char_code;
                    end
                    POS_COMMA: begin
                        if (i_char_code != CHAR_COMMA) n_fbad = 1'b1;
                    end
                    default: ;
                endcase
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // First step: month, shifted year and its terms, time of day.
    assign w_month       = month_decode(r_mon[0], r_mon[1], r_mon[2]);
    assign w_adj         = (w_month.idx == MON_JAN) || (w_month.idx == MON_FEB);
    assign w_year_sh     = r_year + YEAR_BIAS - 14'(w_adj);
    assign w_q4          = w_year_sh[YEAR_W-1:2];
    assign w_div100_prod = 27'(w_year_sh) * DIV100_MUL;
    assign w_div400_prod = 27'(w_q4) * DIV100_MUL;
    assign w_y365        = 22'(w_year_sh) * DAYS_PER_YEAR;
    assign w_tod         = 19'(r_hour) * SECS_PER_HOUR + 19'(r_min) * SECS_PER_MIN
                           + 19'(r_sec);

    // Second step: day count relative to 1970-01-01.
    assign w_days = 23'(r_y365) + 23'(r_q4) - 23'(r_c100) + 23'(r_c400) + 23'(r_doy)
                    + 23'(r_dom) - DAYS_BIAS;

    // Third step: seconds.
    assign w_prod = 40'(r_days) * SECS_PER_DAY;
    assign w_secs = w_prod + 40'(r_tod);

    // Collection registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ovf  <= 1'b0;
            r_fbad <= 1'b0;
            r_day  <= '0;
            r_year <= '0;
            r_hour <= '0;
            r_min  <= '0;
            r_sec  <= '0;
            r_mon  <= '{default: '0};
        end else begin
            r_pos  <= n_pos;
            r_ovf  <= n_ovf;
            r_fbad <= n_fbad;
            r_day  <= n_day;
            r_year <= n_year;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
            r_mon  <= n_mon;
        end
    end

    // Arithmetic stage registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_a) begin
            r_y365 <= w_y365;
            r_q4   <= w_q4;
            r_c100 <= w_div100_prod[DIV100_SHIFT+6:DIV100_SHIFT];
            r_c400 <= w_div400_prod[DIV100_SHIFT+4:DIV100_SHIFT];
            r_doy  <= month_doy(w_month.idx);
            r_dom  <= r_day;
            r_tod  <= w_tod;
            r_ok   <= (r_pos == DATE_LEN) && !r_ovf && !r_fbad && w_month.ok;
        end
        if (i_cmd.calc_b) begin
            r_days <= w_days;
        end
    end

    // Result register: holds a beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_epoch      <= r_ok ? w_secs[EPOCH_W-1:0] : '0;
            r_date_valid <= r_ok;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_epoch_seconds   = r_epoch;
    assign o_date_valid      = r_date_valid;

endmodule

// ===== rtl/http_date_parser_core.sv =====
// Top level of the HTTP date parser: joins the controller and the datapath to
// the character and result channels. Depends on hdp_pkg, hdp_char_if, hdp_date_if.
//
//   channel  | dir | payload                      | beat
//   ---------+-----+------------------------------+-------------------------------
//   i_char   | in  | char_code[7:0], is_last      | one character of the date
//   o_date   | out | epoch_seconds[38:0], date_valid | one parsed date per last beat
//
// One character is taken every cycle while the controller collects. After the last character
// the input is held off while the date arithmetic runs (year terms, day count, seconds, one
// register stage each) and until the result is loaded; the result is then in the output register.
// The output register parts the two sides: the next date's characters are taken
// while a result waits, and the final step waits only if a result is still held.
// Reset (synchronous, active low) clears the position, flags, fields and output valid.
`include "http_date_parser_core_assert.svh"

module http_date_parser_core import hdp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    hdp_char_if.sink   i_char,
    hdp_date_if.source o_date
);

    t_hdp_cmd                  w_cmd;
    t_hdp_status               w_status;
    logic                      w_in_ready;
    logic                      w_in_take;
    logic                      w_out_valid;
    logic signed [EPOCH_W-1:0] w_epoch;
    logic                      w_date_valid;

    // Controller.
    hdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .i_in_last   (i_char.is_last),
        .i_out_ready (o_date.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    hdp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_code     (i_char.char_code),
        .i_cmd           (w_cmd),
        .i_out_ready     (o_date.ready),
        .o_status        (w_status),
        .o_out_valid     (w_out_valid),
        .o_epoch_seconds (w_epoch),
        .o_date_valid    (w_date_valid)
    );

    // Channel connections.
    assign i_char.ready         = w_in_ready;
    assign w_in_take            = i_char.valid && w_in_ready;
    assign o_date.valid         = w_out_valid;
    assign o_date.epoch_seconds = w_epoch;
    assign o_date.date_valid    = w_date_valid;

    // The last character stops the input while the arithmetic runs.
    `HDP_ASSERT_NEXT(a_last_holds_input, i_clk, i_rst_n, w_in_take && i_char.is_last, !i_char.ready)
    // A new result is loaded only into a free or draining output register.
    `HDP_ASSERT_IMPL(a_load_into_free, i_clk, i_rst_n, w_cmd.load_out, !o_date.valid || o_date.ready)
    // A result appearing in an empty register follows its last character through the CALC_A, CALC_B and CALC_C states.
    `HDP_ASSERT_IMPL(a_result_latency, i_clk, i_rst_n, $rose(o_date.valid), $past(w_in_take && i_char.is_last, 4))
    // A rejected date carries zero seconds.
    `HDP_ASSERT_IMPL(a_invalid_is_zero, i_clk, i_rst_n, o_date.valid && !o_date.date_valid, o_date.epoch_seconds == '0)

endmodule
